### design/gkt_pkg.sv
// shared types, constants and a saturation helper for the gated kalman tracker
// no dependencies; used by every module of the block
`default_nettype none

package gkt_pkg;

   // number of tracked components and the fixed component count of the ports
   localparam int GKT_DIMS  = 3;
   localparam int GKT_NCOMP = 3;
   localparam int IDX_W     = 2;

   // register indexes of the configuration space
   localparam logic [2:0] REG_TRANSITION  = 3'd0;
   localparam logic [2:0] REG_OBSERVATION = 3'd1;
   localparam logic [2:0] REG_PROC_NOISE  = 3'd2;
   localparam logic [2:0] REG_MEAS_NOISE  = 3'd3;
   localparam logic [2:0] REG_INIT_VAR    = 3'd4;
   localparam logic [2:0] REG_GATE        = 3'd5;
   localparam logic [2:0] REG_TIMEOUT     = 3'd6;

   // divider geometry: 64-bit numerator scaled by 2^12
   localparam int DIV_W     = 76;
   localparam int DIV_CNT_W = 7;

   typedef struct packed {
      logic [GKT_NCOMP-1:0][31:0] meas;
      logic [31:0]                now_ms;
      logic                       force_stale;
   } gkt_item_type;

   typedef struct packed {
      logic signed [31:0] trans_gain;
      logic signed [31:0] obs_gain;
      logic [31:0]        proc_noise;
      logic [31:0]        meas_noise;
      logic [31:0]        init_var;
      logic [47:0]        gate_thr;
      logic [31:0]        timeout_ms;
   } gkt_cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [32:0]      den;
   } gkt_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quo;
   } gkt_div_rsp_type;

   // saturate a signed value to 32 signed bits
   function automatic logic signed [31:0] gkt_sat32(input logic signed [51:0] v);
      logic signed [31:0] res;
      if (v > 52'sd2147483647) begin
         res = 32'sh7fffffff;
      end else if (v < -52'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### design/gkt_front.sv
// front end: accepts measurement transactions into a two-entry queue
// depends on gkt_pkg for the item type
`default_nettype none

module gkt_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  gkt_pkg::gkt_item_type req_item,
   output logic                q_valid,
   output gkt_pkg::gkt_item_type q_item,
   input  wire                 q_pop
);

   gkt_pkg::gkt_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // handshake and queue pointers
   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

`default_nettype wire

### design/gkt_div.sv
// restoring divider, one quotient bit per cycle, shared by distance and gain
// depends on gkt_pkg for the request and response types
`default_nettype none

module gkt_div (
   input  wire                     clock,
   input  wire                     reset,
   input  gkt_pkg::gkt_div_req_type req,
   output gkt_pkg::gkt_div_rsp_type rsp
);

   logic [gkt_pkg::DIV_W-1:0]     num_ff, num_in;
   logic [32:0]                   rem_ff, rem_in;
   logic [32:0]                   den_ff, den_in;
   logic [gkt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [33:0]                   trial;
   logic                          ge;

   // one restoring step
   assign trial = {rem_ff, num_ff[gkt_pkg::DIV_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start && !busy_ff) begin
         num_in  = req.num;
         rem_in  = 33'd0;
         den_in  = req.den;
         cnt_in  = gkt_pkg::DIV_CNT_W'(gkt_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         num_in = {num_ff[gkt_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == gkt_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;

endmodule

`default_nettype wire

### design/gkt_back.sv
// back end: sequencer with one shared multiplier carrying out predict, gate, correct
// depends on gkt_pkg and drives the shared gkt_div unit
`default_nettype none

module gkt_back (
   input  wire                        clock,
   input  wire                        reset,
   input  gkt_pkg::gkt_cfg_type        cfg,
   input  wire                        q_valid,
   input  gkt_pkg::gkt_item_type       q_item,
   output logic                       q_pop,
   output gkt_pkg::gkt_div_req_type    div_req,
   input  gkt_pkg::gkt_div_rsp_type    div_rsp,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [gkt_pkg::GKT_NCOMP-1:0][31:0] rsp_est,
   output logic                       rsp_accepted,
   output logic                       rsp_reinitialised
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_W0   = 5'd1;
   localparam logic [4:0] S_W1   = 5'd2;
   localparam logic [4:0] S_W2   = 5'd3;
   localparam logic [4:0] S_W3   = 5'd4;
   localparam logic [4:0] S_XP0  = 5'd5;
   localparam logic [4:0] S_XP1  = 5'd6;
   localparam logic [4:0] S_RS0  = 5'd7;
   localparam logic [4:0] S_RS1  = 5'd8;
   localparam logic [4:0] S_MG   = 5'd9;
   localparam logic [4:0] S_DS   = 5'd10;
   localparam logic [4:0] S_DV   = 5'd11;
   localparam logic [4:0] S_Q0   = 5'd12;
   localparam logic [4:0] S_Q1   = 5'd13;
   localparam logic [4:0] S_Q2   = 5'd14;
   localparam logic [4:0] S_Q3   = 5'd15;
   localparam logic [4:0] S_GATE = 5'd16;
   localparam logic [4:0] S_KDS  = 5'd17;
   localparam logic [4:0] S_KDV  = 5'd18;
   localparam logic [4:0] S_KM0  = 5'd19;
   localparam logic [4:0] S_KM1  = 5'd20;
   localparam logic [4:0] S_KP0  = 5'd21;
   localparam logic [4:0] S_KP1  = 5'd22;
   localparam logic [4:0] S_KR0  = 5'd23;
   localparam logic [4:0] S_KR1  = 5'd24;
   localparam logic [4:0] S_OUT  = 5'd25;

   localparam logic [gkt_pkg::IDX_W-1:0] IDX_LAST = gkt_pkg::IDX_W'(gkt_pkg::GKT_DIMS - 1);

   logic [4:0] state_ff, state_in;

   // filter state
   logic signed [31:0] est_ff [gkt_pkg::GKT_NCOMP];
   logic signed [31:0] est_in [gkt_pkg::GKT_NCOMP];
   logic [31:0] var_ff, var_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] since_ff, since_in;
   logic        stale_ff, stale_in;

   // per-transaction working registers
   logic signed [31:0] z_ff  [gkt_pkg::GKT_NCOMP];
   logic signed [31:0] z_in  [gkt_pkg::GKT_NCOMP];
   logic signed [31:0] xp_ff [gkt_pkg::GKT_NCOMP];
   logic signed [31:0] xp_in [gkt_pkg::GKT_NCOMP];
   logic signed [31:0] r_ff  [gkt_pkg::GKT_NCOMP];
   logic signed [31:0] r_in  [gkt_pkg::GKT_NCOMP];
   logic [31:0] now_ff, now_in;
   logic [31:0] ppri_ff, ppri_in;
   logic [32:0] den_ff, den_in;
   logic [63:0] wide_ff, wide_in;
   logic [31:0] hi_ff, hi_in;
   logic [99:0] norm_ff, norm_in;
   logic [99:0] t2_ff, t2_in;
   logic [47:0] d_ff, d_in;
   logic signed [31:0] k_ff, k_in;
   logic signed [32:0] m_ff, m_in;
   logic [gkt_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic selc_ff, selc_in;
   logic sqt_ff, sqt_in;
   logic reinit_ff, reinit_in;
   logic acc_ff, acc_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_est_ff [gkt_pkg::GKT_NCOMP];
   logic [31:0] rsp_est_in [gkt_pkg::GKT_NCOMP];
   logic        rsp_acc_ff, rsp_acc_in;
   logic        rsp_reinit_ff, rsp_reinit_in;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, prod_in;

   // helper terms
   logic signed [31:0] g_sel;
   logic [31:0] g_abs, c_abs, x_sel, noise_sel, r_abs;
   logic [95:0] w_full, w_rnd;
   logic [31:0] w_sat, w_res;
   logic [32:0] w_sum;
   logic signed [66:0] sum16, sum28;
   logic signed [50:0] r16;
   logic signed [38:0] r28;
   logic signed [51:0] diff;
   logic signed [40:0] p_new;
   logic [47:0] sq_val;
   logic [30:0] kq;
   logic stale_eff;

   assign g_sel     = selc_ff ? cfg.obs_gain : cfg.trans_gain;
   assign g_abs     = g_sel[31] ? (~g_sel + 32'd1) : g_sel;
   assign c_abs     = cfg.obs_gain[31] ? (~cfg.obs_gain + 32'd1) : cfg.obs_gain;
   assign x_sel     = selc_ff ? ppri_ff : var_ff;
   assign noise_sel = selc_ff ? cfg.meas_noise : cfg.proc_noise;
   assign r_abs     = r_ff[idx_ff][31] ? (~r_ff[idx_ff] + 32'd1) : r_ff[idx_ff];

   // rounded 32-bit scaling of a 96-bit product, plus noise
   assign w_full = {prod_ff[63:0], 32'd0} + {32'd0, wide_ff};
   assign w_rnd  = w_full + 96'h8000_0000;
   assign w_sat  = (|w_rnd[95:64]) ? 32'hffff_ffff : w_rnd[63:32];
   assign w_sum  = {1'b0, w_sat} + {1'b0, noise_sel};
   assign w_res  = w_sum[32] ? 32'hffff_ffff : w_sum[31:0];

   // round half up after shifts of 16 and 28
   assign sum16 = {prod_ff[65], prod_ff} + 67'sd32768;
   assign sum28 = {prod_ff[65], prod_ff} + 67'sd134217728;
   assign r16   = $signed(sum16[66:16]);
   assign r28   = $signed(sum28[66:28]);
   assign diff  = {{20{z_ff[idx_ff][31]}}, z_ff[idx_ff]} - {r16[50], r16};
   assign p_new = {9'd0, ppri_ff} - {{2{r28[38]}}, r28};

   assign sq_val    = sqt_ff ? cfg.gate_thr : d_ff;
   assign kq        = (|div_rsp.quo[75:31]) ? 31'h7fff_ffff : div_rsp.quo[30:0];
   assign stale_eff = stale_ff || q_item.force_stale;

   assign prod_in = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      var_in    = var_ff;
      last_in   = last_ff;
      since_in  = since_ff;
      stale_in  = stale_ff;
      now_in    = now_ff;
      ppri_in   = ppri_ff;
      den_in    = den_ff;
      wide_in   = wide_ff;
      hi_in     = hi_ff;
      norm_in   = norm_ff;
      t2_in     = t2_ff;
      d_in      = d_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      idx_in    = idx_ff;
      selc_in   = selc_ff;
      sqt_in    = sqt_ff;
      reinit_in = reinit_ff;
      acc_in    = acc_ff;
      for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
         est_in[i]     = est_ff[i];
         z_in[i]       = z_ff[i];
         xp_in[i]      = xp_ff[i];
         r_in[i]       = r_ff[i];
         rsp_est_in[i] = rsp_est_ff[i];
      end
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_acc_in    = rsp_acc_ff;
      rsp_reinit_in = rsp_reinit_ff;
      mul_a         = '0;
      mul_b         = '0;
      q_pop         = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = {prod_ff[63:0], 12'd0};
      div_req.den   = den_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               now_in  = q_item.now_ms;
               selc_in = 1'b0;
               sqt_in  = 1'b0;
               norm_in = '0;
               t2_in   = '0;
               idx_in  = '0;
               for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
                  z_in[i] = q_item.meas[i];
               end
               reinit_in = stale_eff || (since_ff >= cfg.timeout_ms);
               stale_in  = stale_eff;
               // re-seed from the measurement
               if (stale_eff || (since_ff >= cfg.timeout_ms)) begin
                  for (int i = 0; i < gkt_pkg::GKT_DIMS; i++) begin
                     est_in[i] = q_item.meas[i];
                  end
                  var_in   = cfg.init_var;
                  last_in  = q_item.now_ms;
                  since_in = '0;
                  stale_in = 1'b0;
               end
               state_in = S_W0;
            end
         end
         // prior and innovation variance, twice through
         S_W0: begin
            mul_a    = {1'b0, g_abs};
            mul_b    = {1'b0, g_abs};
            state_in = S_W1;
         end
         S_W1: begin
            hi_in    = prod_ff[63:32];
            mul_a    = {1'b0, x_sel};
            mul_b    = {1'b0, prod_ff[31:0]};
            state_in = S_W2;
         end
         S_W2: begin
            wide_in  = prod_ff[63:0];
            mul_a    = {1'b0, x_sel};
            mul_b    = {1'b0, hi_ff};
            state_in = S_W3;
         end
         S_W3: begin
            if (!selc_ff) begin
               ppri_in  = w_res;
               selc_in  = 1'b1;
               state_in = S_W0;
            end else begin
               den_in   = {1'b0, w_res} + 33'd1;
               idx_in   = '0;
               state_in = S_XP0;
            end
         end
         // prediction and residual of one component
         S_XP0: begin
            mul_a    = {cfg.trans_gain[31], cfg.trans_gain};
            mul_b    = {est_ff[idx_ff][31], est_ff[idx_ff]};
            state_in = S_XP1;
         end
         S_XP1: begin
            xp_in[idx_ff] = gkt_pkg::gkt_sat32({r16[50], r16});
            state_in      = S_RS0;
         end
         S_RS0: begin
            mul_a    = {cfg.obs_gain[31], cfg.obs_gain};
            mul_b    = {xp_ff[idx_ff][31], xp_ff[idx_ff]};
            state_in = S_RS1;
         end
         S_RS1: begin
            r_in[idx_ff] = gkt_pkg::gkt_sat32(diff);
            state_in     = S_MG;
         end
         S_MG: begin
            mul_a    = {1'b0, r_abs};
            mul_b    = {1'b0, r_abs};
            state_in = S_DS;
         end
         S_DS: begin
            div_req.start = 1'b1;
            state_in      = S_DV;
         end
         S_DV: begin
            if (div_rsp.done) begin
               d_in     = (|div_rsp.quo[75:48]) ? 48'hffff_ffff_ffff : div_rsp.quo[47:0];
               state_in = S_Q0;
            end
         end
         // square a 48-bit value into the distance or threshold sum
         S_Q0: begin
            mul_a    = {1'b0, sq_val[31:0]};
            mul_b    = {1'b0, sq_val[31:0]};
            state_in = S_Q1;
         end
         S_Q1: begin
            if (sqt_ff) t2_in = t2_ff + {36'd0, prod_ff[63:0]};
            else norm_in = norm_ff + {36'd0, prod_ff[63:0]};
            mul_a    = {17'd0, sq_val[47:32]};
            mul_b    = {1'b0, sq_val[31:0]};
            state_in = S_Q2;
         end
         S_Q2: begin
            if (sqt_ff) t2_in = t2_ff + {3'd0, prod_ff[63:0], 33'd0};
            else norm_in = norm_ff + {3'd0, prod_ff[63:0], 33'd0};
            mul_a    = {17'd0, sq_val[47:32]};
            mul_b    = {17'd0, sq_val[47:32]};
            state_in = S_Q3;
         end
         S_Q3: begin
            if (sqt_ff) begin
               t2_in    = t2_ff + {4'd0, prod_ff[31:0], 64'd0};
               state_in = S_GATE;
            end else begin
               norm_in = norm_ff + {4'd0, prod_ff[31:0], 64'd0};
               if (idx_ff == IDX_LAST) begin
                  sqt_in   = 1'b1;
                  state_in = S_Q0;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_XP0;
               end
            end
         end
         // gate decision
         S_GATE: begin
            acc_in = (norm_ff < t2_ff);
            mul_a  = {1'b0, ppri_ff};
            mul_b  = {1'b0, c_abs};
            if (norm_ff < t2_ff) begin
               state_in = S_KDS;
            end else begin
               for (int i = 0; i < gkt_pkg::GKT_DIMS; i++) begin
                  est_in[i] = xp_ff[i];
               end
               var_in   = ppri_ff;
               since_in = now_ff - last_ff;
               state_in = S_OUT;
            end
         end
         // gain, covariance and estimate update
         S_KDS: begin
            div_req.start = 1'b1;
            state_in      = S_KDV;
         end
         S_KDV: begin
            if (div_rsp.done) begin
               k_in     = cfg.obs_gain[31] ? -$signed({1'b0, kq}) : $signed({1'b0, kq});
               state_in = S_KM0;
            end
         end
         S_KM0: begin
            mul_a    = {k_ff[31], k_ff};
            mul_b    = {cfg.obs_gain[31], cfg.obs_gain};
            state_in = S_KM1;
         end
         S_KM1: begin
            if (r16 > 51'sd2147483648) m_in = 33'sd2147483648;
            else if (r16 < -51'sd2147483648) m_in = -33'sd2147483648;
            else m_in = r16[32:0];
            state_in = S_KP0;
         end
         S_KP0: begin
            mul_a    = {1'b0, ppri_ff};
            mul_b    = m_ff;
            state_in = S_KP1;
         end
         S_KP1: begin
            if (p_new < 41'sd0) var_in = '0;
            else if (p_new > 41'sd4294967295) var_in = 32'hffff_ffff;
            else var_in = p_new[31:0];
            idx_in   = '0;
            state_in = S_KR0;
         end
         S_KR0: begin
            mul_a    = {k_ff[31], k_ff};
            mul_b    = {r_ff[idx_ff][31], r_ff[idx_ff]};
            state_in = S_KR1;
         end
         S_KR1: begin
            est_in[idx_ff] = gkt_pkg::gkt_sat32({{20{xp_ff[idx_ff][31]}}, xp_ff[idx_ff]} +
                                                {{13{r28[38]}}, r28});
            if (idx_ff == IDX_LAST) begin
               last_in  = now_ff;
               since_in = '0;
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_KR0;
            end
         end
         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = acc_ff;
               rsp_reinit_in = reinit_ff;
               for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
                  rsp_est_in[i] = est_ff[i];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         var_ff       <= '0;
         last_ff      <= '0;
         since_ff     <= '0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         selc_ff      <= 1'b0;
         sqt_ff       <= 1'b0;
         for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
            est_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         var_ff       <= var_in;
         last_ff      <= last_in;
         since_ff     <= since_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         selc_ff      <= selc_in;
         sqt_ff       <= sqt_in;
         for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
            est_ff[i] <= est_in[i];
         end
      end
   end

   // working payload, no reset
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      ppri_ff       <= ppri_in;
      den_ff        <= den_in;
      wide_ff       <= wide_in;
      hi_ff         <= hi_in;
      norm_ff       <= norm_in;
      t2_ff         <= t2_in;
      d_ff          <= d_in;
      k_ff          <= k_in;
      m_ff          <= m_in;
      reinit_ff     <= reinit_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_reinit_ff <= rsp_reinit_in;
      for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
         z_ff[i]       <= z_in[i];
         xp_ff[i]      <= xp_in[i];
         r_ff[i]       <= r_in[i];
         rsp_est_ff[i] <= rsp_est_in[i];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_reinitialised = rsp_reinit_ff;
   always_comb begin
      for (int i = 0; i < gkt_pkg::GKT_NCOMP; i++) begin
         rsp_est[i] = rsp_est_ff[i];
      end
   end

`ifndef NO_ASSERTIONS
   // an applied correction always restarts the time since the last good one
   a_since_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && acc_ff) |-> (since_ff == 32'd0))
      else $error("time since correction not cleared on accept");

   // the track is never stale once a transaction has been processed
   a_not_stale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> !stale_ff)
      else $error("track still stale at result");

   // the divider is idle whenever the sequencer waits for a transaction
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while sequencer idle");

   // a queued transaction is only taken when the sequencer is idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_W0))
      else $error("transaction popped outside idle");
`endif

endmodule

`default_nettype wire

### design/gated_kalman_tracker.sv
// top level: register file, front queue, back sequencer and shared divider
// depends on gkt_pkg, gkt_front, gkt_div and gkt_back
//
//  channel  handshake                 payload
//  req      req_valid / req_ready     meas x y z, now_ms, force_stale
//  rsp      rsp_valid / rsp_ready     est x y z, accepted, reinitialised
//  csr      psel penable pwrite       paddr, pwdata / prdata, pready tied high
//
// a transaction runs the restoring divider, one quotient bit per cycle over 76 bits,
// once per component and once more for the gain when the correction is applied.
// synchronous active-high reset: track stale, estimate zero, registers at defaults.
// the input queue holds two transactions and the output register lets the next
// transaction start while a result waits to be taken.
`default_nettype none

module gated_kalman_tracker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_meas_x,
   input  wire  [31:0] req_meas_y,
   input  wire  [31:0] req_meas_z,
   input  wire  [31:0] req_now_ms,
   input  wire         req_force_stale,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_est_x,
   output logic [31:0] rsp_est_y,
   output logic [31:0] rsp_est_z,
   output logic        rsp_accepted,
   output logic        rsp_reinitialised,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [5:0]  paddr,
   input  wire  [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   gkt_pkg::gkt_cfg_type     cfg_ff, cfg_in;
   gkt_pkg::gkt_item_type    req_item;
   gkt_pkg::gkt_item_type    q_item;
   gkt_pkg::gkt_div_req_type div_req;
   gkt_pkg::gkt_div_rsp_type div_rsp;
   logic                     q_valid;
   logic                     q_pop;
   logic                     wr_en;
   logic [2:0]               reg_idx;
   logic [gkt_pkg::GKT_NCOMP-1:0][31:0] est;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite && pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            gkt_pkg::REG_TRANSITION:  cfg_in.trans_gain = pwdata[31:0];
            gkt_pkg::REG_OBSERVATION: cfg_in.obs_gain   = pwdata[31:0];
            gkt_pkg::REG_PROC_NOISE:  cfg_in.proc_noise = pwdata[31:0];
            gkt_pkg::REG_MEAS_NOISE:  cfg_in.meas_noise = pwdata[31:0];
            gkt_pkg::REG_INIT_VAR:    cfg_in.init_var   = pwdata[31:0];
            gkt_pkg::REG_GATE:        cfg_in.gate_thr   = pwdata[47:0];
            gkt_pkg::REG_TIMEOUT:     cfg_in.timeout_ms = pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans_gain <= 32'sd65536;
         cfg_ff.obs_gain   <= 32'sd65536;
         cfg_ff.proc_noise <= 32'd26844;
         cfg_ff.meas_noise <= 32'd26844;
         cfg_ff.init_var   <= 32'd2684355;
         cfg_ff.gate_thr   <= 48'd655360000;
         cfg_ff.timeout_ms <= 32'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         gkt_pkg::REG_TRANSITION:  prdata = {32'd0, cfg_ff.trans_gain};
         gkt_pkg::REG_OBSERVATION: prdata = {32'd0, cfg_ff.obs_gain};
         gkt_pkg::REG_PROC_NOISE:  prdata = {32'd0, cfg_ff.proc_noise};
         gkt_pkg::REG_MEAS_NOISE:  prdata = {32'd0, cfg_ff.meas_noise};
         gkt_pkg::REG_INIT_VAR:    prdata = {32'd0, cfg_ff.init_var};
         gkt_pkg::REG_GATE:        prdata = {16'd0, cfg_ff.gate_thr};
         gkt_pkg::REG_TIMEOUT:     prdata = {32'd0, cfg_ff.timeout_ms};
         default:                  prdata = '0;
      endcase
   end

   assign req_item.meas        = {req_meas_z, req_meas_y, req_meas_x};
   assign req_item.now_ms      = req_now_ms;
   assign req_item.force_stale = req_force_stale;

   gkt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   gkt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gkt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .div_req           (div_req),
      .div_rsp           (div_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_est           (est),
      .rsp_accepted      (rsp_accepted),
      .rsp_reinitialised (rsp_reinitialised)
   );

   assign rsp_est_x = est[0];
   assign rsp_est_y = est[1];
   assign rsp_est_z = est[2];

endmodule

`default_nettype wire
